// File: rtl/mbae_pkg.sv
package mbae_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] HIGH_BIT     = 8'h80;
  localparam logic [3:0] NIB_MASK     = 4'hF;
  localparam logic [3:0] NIB_TEN      = 4'd10;

  // Most characters one byte can cause: colon, two hex, two LRC hex, CR, LF
  localparam int unsigned MAX_CHARS = 7;
  localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);

  // Set of characters caused by one byte, handed to the output stage
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;  // chars[0] is sent first
    logic [CNT_W-1:0]          count;  // number of valid chars, 2..7
  } char_grp_t;

  // Upper-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NIB_MASK;
    if (n < NIB_TEN) begin
      return CHAR_ZERO + {4'd0, n};
    end
    return CHAR_UPPER_A + {4'd0, n - NIB_TEN};
  endfunction

endpackage

// File: rtl/modbus_ascii_frame_encoder_top.sv
// Channel   Dir  Width  Contents
// s_axis    in   8+1+1  tdata=frame_byte, tuser=frame_first, tlast=frame_last
// m_axis    out  8+1    tdata=out_char, tlast=out_end
// cfg       in   1      set_high_bit, written when cfg_we_i is high
//
// Each byte gives 2 to 7 characters, one per cycle on m_axis while m_axis is
// ready; a mid-frame byte gives 2 characters, held in the output buffer.
// A one-entry input register takes the next byte while the buffer drains.
// Reset clears the running sum and sets the high-bit mode.
// A stall on m_axis holds the buffer; s_axis stalls once the input register
// is full.
module modbus_ascii_frame_encoder_top
  import mbae_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] frame_byte
  input  logic       s_axis_tuser_i,   // frame_first
  input  logic       s_axis_tlast_i,   // frame_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o,   // out_end
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i       // set_high_bit
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q, in_last_q;
  logic       high_bit_q;
  logic       accept, load, free;
  char_grp_t  grp;

  assign s_axis_tready_o = !in_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load            = in_valid_q && free;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_bit_q <= 1'b1;
    end else if (cfg_we_i) begin
      high_bit_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  mbae_encode u_encode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .byte_i     (in_byte_q),
    .first_i    (in_first_q),
    .last_i     (in_last_q),
    .high_bit_i (high_bit_q),
    .grp_o      (grp)
  );

  mbae_serial u_serial (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .grp_i           (grp),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: rtl/mbae_encode.sv
module mbae_encode
  import mbae_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,       // byte moves to the output stage this cycle
  input  logic [7:0] byte_i,
  input  logic      first_i,
  input  logic      last_i,
  input  logic      high_bit_i,
  output char_grp_t grp_o
);

  logic [7:0] byte_sum_q, byte_sum_d;
  logic [7:0] base_sum, new_sum, lrc;
  logic [MAX_CHARS-1:0][7:0] seq;
  logic [7:0] hb_mask;

  // Running sum: restart on a frame start, clear after the LRC
  assign base_sum   = first_i ? 8'd0 : byte_sum_q;
  assign new_sum    = base_sum + byte_i;
  assign lrc        = 8'd0 - new_sum;
  assign byte_sum_d = last_i ? 8'd0 : new_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_sum_q <= 8'd0;
    end else if (load_i) begin
      byte_sum_q <= byte_sum_d;
    end
  end

  // Full sequence with header; dropped by one slot when there is no header
  assign seq[0] = CHAR_COLON;
  assign seq[1] = hex_digit(byte_i[7:4]);
  assign seq[2] = hex_digit(byte_i[3:0]);
  assign seq[3] = hex_digit(lrc[7:4]);
  assign seq[4] = hex_digit(lrc[3:0]);
  assign seq[5] = CHAR_CR;
  assign seq[6] = CHAR_LF;

  assign hb_mask = high_bit_i ? HIGH_BIT : 8'd0;

  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (first_i) begin
        grp_o.chars[i] = seq[i] | hb_mask;
      end else if (i < MAX_CHARS - 1) begin
        grp_o.chars[i] = seq[i+1] | hb_mask;
      end else begin
        grp_o.chars[i] = seq[0] | hb_mask;
      end
    end
    grp_o.count = CNT_W'(2) + CNT_W'(first_i) + (last_i ? CNT_W'(4) : CNT_W'(0));
  end

endmodule

// File: rtl/mbae_serial.sv
module mbae_serial
  import mbae_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  char_grp_t  grp_i,
  output logic       free_o,     // buffer can take a new group this cycle
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_char
  output logic       m_axis_tlast_o   // out_end
);

  char_grp_t        buf_q;
  logic             busy_q;
  logic [CNT_W-1:0] idx_q;
  logic             at_end, take;

  assign at_end = (idx_q == buf_q.count - CNT_W'(1));
  assign take   = busy_q && m_axis_tready_i;
  assign free_o = !busy_q || (take && at_end);

  // Character buffer and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (at_end) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= grp_i;
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = buf_q.chars[idx_q[CNT_W-1:0]];
  assign m_axis_tlast_o  = at_end;

endmodule
